// File: sv/fcca_pkg.sv
// fcca_pkg: shared types and constants of the cluster allocation table
// used by fcca_ctrl, fcca_dp and fat_cluster_chain_allocator
`default_nettype none

package fcca_pkg;

  localparam int TABLE_DEPTH = 65536;
  localparam int CW          = 17;
  localparam int LW          = 28;

  localparam logic [LW-1:0] LINK_EOC     = 28'hFFFFFFF;
  localparam logic [LW-1:0] LINK_EOC_MIN = 28'hFFFFFF8;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_LINK = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] cluster;
    logic [16:0] count;
    logic [27:0] value;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [27:0] result_value;
    logic [16:0] free_left;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_COLLECT,
    S_SEARCH,
    S_ALLOC_END,
    S_FREE_WALK,
    S_RW
  } state_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_START,
    OP_COLLECT,
    OP_SEARCH,
    OP_ALLOC_END,
    OP_FREE,
    OP_RW
  } dp_op_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_FIRST,
    SEL_ENTRY
  } res_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     emit;
    status_t  status;
    res_sel_t sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic alloc_bad;
    logic addr_bad;
    logic cur_end;
    logic entry_free;
    logic take_last;
    logic have;
    logic link_eoc;
    logic link_bad;
    logic is_read;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/fcca_ram.sv
// fcca_ram: generic single write port, single read port ram
// read data registered; no dependencies
`default_nettype none

module fcca_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/fcca_ctrl.sv
// fcca_ctrl: command sequencer of the cluster allocation table
// depends on fcca_pkg; drives fcca_dp through ctrl_cmd_t, reads dp_stat_t
`default_nettype none

module fcca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  fcca_pkg::cmd_t    req_cmd,
  input  fcca_pkg::dp_stat_t stat,
  output fcca_pkg::ctrl_cmd_t ctl,
  output logic              busy
);

  import fcca_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          unique case (req_cmd)
            CMD_ALLOC: state_next = stat.alloc_bad ? S_IDLE : S_COLLECT;
            CMD_FREE:  state_next = stat.addr_bad ? S_IDLE : S_FREE_WALK;
            default:   state_next = stat.addr_bad ? S_IDLE : S_RW;
          endcase
        end
      end
      S_COLLECT: begin
        priority if (stat.cur_end) state_next = S_ALLOC_END;
        else if (stat.entry_free && stat.take_last) state_next = S_SEARCH;
        else state_next = S_COLLECT;
      end
      S_SEARCH: begin
        if (stat.cur_end || stat.entry_free) state_next = S_ALLOC_END;
      end
      S_ALLOC_END: state_next = S_IDLE;
      S_FREE_WALK: begin
        if (stat.entry_free || stat.link_eoc || stat.link_bad) state_next = S_IDLE;
      end
      S_RW: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.op     = OP_NOP;
    ctl.emit   = 1'b0;
    ctl.status = ST_OK;
    ctl.sel    = SEL_ZERO;
    unique case (state)
      S_CLEAR: ctl.op = OP_CLEAR;
      S_IDLE: begin
        if (start) begin
          ctl.op = OP_START;
          if (req_cmd == CMD_ALLOC) begin
            if (stat.alloc_bad) begin
              ctl.emit   = 1'b1;
              ctl.status = ST_NO_SPACE;
            end
          end else if (stat.addr_bad) begin
            ctl.emit   = 1'b1;
            ctl.status = ST_BAD_LINK;
          end
        end
      end
      S_COLLECT: ctl.op = OP_COLLECT;
      S_SEARCH:  ctl.op = OP_SEARCH;
      S_ALLOC_END: begin
        ctl.op   = OP_ALLOC_END;
        ctl.emit = 1'b1;
        if (stat.have) begin
          ctl.sel = SEL_FIRST;
        end else begin
          ctl.status = ST_NO_SPACE;
        end
      end
      S_FREE_WALK: begin
        ctl.op = OP_FREE;
        priority if (stat.entry_free) begin
          ctl.emit   = 1'b1;
          ctl.status = ST_BAD_LINK;
        end else if (stat.link_eoc) begin
          ctl.emit = 1'b1;
        end else if (stat.link_bad) begin
          ctl.emit   = 1'b1;
          ctl.status = ST_BAD_LINK;
        end else begin
          ctl.emit = 1'b0;
        end
      end
      S_RW: begin
        ctl.op   = OP_RW;
        ctl.emit = 1'b1;
        ctl.sel  = stat.is_read ? SEL_ENTRY : SEL_ZERO;
      end
      default: ctl.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/fcca_dp.sv
// fcca_dp: datapath of the cluster allocation table: walk pointer,
// chain bookkeeping, free count, hint, table port control and result register
// depends on fcca_pkg
`default_nettype none

module fcca_dp #(
  parameter int USABLE = 65536,
  parameter int AW     = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  fcca_pkg::ctrl_cmd_t      ctl,
  input  fcca_pkg::req_t           req,
  output fcca_pkg::dp_stat_t       stat,
  output logic                     ram_we,
  output logic [AW-1:0]            ram_waddr,
  output logic [fcca_pkg::LW-1:0]  ram_wdata,
  output logic [AW-1:0]            ram_raddr,
  input  logic [fcca_pkg::LW-1:0]  ram_rdata,
  output logic                     done,
  output fcca_pkg::rsp_t           rsp
);

  import fcca_pkg::*;

  localparam logic [CW-1:0] USABLE_C = CW'(USABLE);

  cmd_t          cmd_q;
  logic [LW-1:0] val_q;
  logic [CW-1:0] cur;
  logic [CW-1:0] prev;
  logic [CW-1:0] first;
  logic [CW-1:0] left;
  logic [CW-1:0] taken;
  logic          have;
  logic [CW-1:0] free_total;
  logic [CW-1:0] hint;
  rsp_t          res;

  logic [CW-1:0] cur_next;
  logic [CW-1:0] prev_next;
  logic [CW-1:0] first_next;
  logic [CW-1:0] left_next;
  logic [CW-1:0] taken_next;
  logic          have_next;
  logic [CW-1:0] free_total_next;
  logic [CW-1:0] hint_next;
  logic [LW-1:0] res_value;

  assign stat.clr_last   = (cur == USABLE_C - 1'b1);
  assign stat.alloc_bad  = (req.count == '0) || (req.count > free_total);
  assign stat.addr_bad   = (req.cluster < 16'd2) || ({1'b0, req.cluster} >= USABLE_C);
  assign stat.cur_end    = (cur >= USABLE_C);
  assign stat.entry_free = (ram_rdata == '0);
  assign stat.take_last  = (left == CW'(1));
  assign stat.have       = have;
  assign stat.link_eoc   = (ram_rdata >= LINK_EOC_MIN);
  assign stat.link_bad   = (ram_rdata < LW'(2)) || (ram_rdata >= LW'(USABLE))
                           || (ram_rdata == LW'(cur));
  assign stat.is_read    = (cmd_q == CMD_READ);

  assign ram_raddr = cur_next[AW-1:0];

  always_comb begin
    cur_next        = cur;
    prev_next       = prev;
    first_next      = first;
    left_next       = left;
    taken_next      = taken;
    have_next       = have;
    free_total_next = free_total;
    hint_next       = hint;
    ram_we          = 1'b0;
    ram_waddr       = cur[AW-1:0];
    ram_wdata       = '0;
    unique case (ctl.op)
      OP_CLEAR: begin
        ram_we   = 1'b1;
        cur_next = cur + 1'b1;
      end
      OP_START: begin
        cur_next   = (req.cmd == CMD_ALLOC) ? hint : {1'b0, req.cluster};
        left_next  = req.count;
        taken_next = '0;
        have_next  = 1'b0;
      end
      OP_COLLECT: begin
        if (!stat.cur_end) begin
          if (stat.entry_free) begin
            if (have) begin
              ram_we    = 1'b1;
              ram_waddr = prev[AW-1:0];
              ram_wdata = LW'(cur);
            end else begin
              first_next = cur;
            end
            have_next  = 1'b1;
            prev_next  = cur;
            left_next  = left - 1'b1;
            taken_next = taken + 1'b1;
          end
          cur_next = cur + 1'b1;
        end
      end
      OP_SEARCH: begin
        if (!stat.cur_end && !stat.entry_free) cur_next = cur + 1'b1;
      end
      OP_ALLOC_END: begin
        if (have) begin
          ram_we          = 1'b1;
          ram_waddr       = prev[AW-1:0];
          ram_wdata       = LINK_EOC;
          free_total_next = free_total - taken;
          hint_next       = cur;
        end
      end
      OP_FREE: begin
        if (!stat.entry_free) begin
          ram_we          = 1'b1;
          free_total_next = free_total + 1'b1;
          if (cur < hint) hint_next = cur;
          if (!stat.link_eoc && !stat.link_bad) cur_next = ram_rdata[CW-1:0];
        end
      end
      OP_RW: begin
        if (cmd_q == CMD_WRITE) begin
          ram_we    = 1'b1;
          ram_wdata = val_q;
          if (stat.entry_free && val_q != '0) begin
            free_total_next = free_total - 1'b1;
          end else if (!stat.entry_free && val_q == '0) begin
            free_total_next = free_total + 1'b1;
            if (cur < hint) hint_next = cur;
          end
        end
      end
      default: cur_next = cur;
    endcase
  end

  always_comb begin
    unique case (ctl.sel)
      SEL_FIRST: res_value = LW'(first);
      SEL_ENTRY: res_value = ram_rdata;
      default:   res_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur        <= '0;
      have       <= 1'b0;
      free_total <= CW'(USABLE - 2);
      hint       <= CW'(2);
      done       <= 1'b0;
    end else begin
      cur        <= cur_next;
      have       <= have_next;
      free_total <= free_total_next;
      hint       <= hint_next;
      done       <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_START) begin
      cmd_q <= req.cmd;
      val_q <= req.value;
    end
    prev  <= prev_next;
    first <= first_next;
    left  <= left_next;
    taken <= taken_next;
    if (ctl.emit) begin
      res.status       <= ctl.status;
      res.result_value <= res_value;
      res.free_left    <= free_total_next;
    end
  end

  assign rsp = res;

endmodule

`default_nettype wire

// File: sv/fat_cluster_chain_allocator.sv
// fat_cluster_chain_allocator: on-chip cluster link table with allocate, free,
// read and write commands; one command at a time, busy high until it is done.
// a rejected command is answered while busy stays low; free walks the chain it is given;
// allocate walks from the hint to the next free entry after the new chain.
// the table ram walks one entry per cycle through its single read port.
// reset: sync, then clears all min(CLUSTERS,65536) table entries with busy high.
`default_nettype none

module fat_cluster_chain_allocator #(
  parameter int CLUSTERS = 65536
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  fcca_pkg::req_t  req,
  output logic            done,
  output fcca_pkg::rsp_t  rsp
);

  import fcca_pkg::*;

  localparam int USABLE = (CLUSTERS < TABLE_DEPTH) ? CLUSTERS : TABLE_DEPTH;
  localparam int AW     = $clog2(USABLE);

  ctrl_cmd_t     ctl;
  dp_stat_t      stat;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [LW-1:0] ram_rdata;

  fcca_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req_cmd (req.cmd),
    .stat    (stat),
    .ctl     (ctl),
    .busy    (busy)
  );

  fcca_dp #(
    .USABLE (USABLE),
    .AW     (AW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .req       (req),
    .stat      (stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .done      (done),
    .rsp       (rsp)
  );

  fcca_ram #(
    .WIDTH (LW),
    .DEPTH (USABLE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !ram_we)
    else $error("table written while idle");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result without a request in flight");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_OK |-> rsp.result_value == '0)
    else $error("failed command returned a nonzero value");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.free_left <= CW'(USABLE - 2))
    else $error("free count above usable clusters");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking testbench for fat_cluster_chain_allocator (default CLUSTERS)
// keeps its own copy of the link table, free count and hint to predict each response
// depends on fcca_pkg and the allocator rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcca_pkg::*;

  localparam int USABLE      = 65536;
  localparam int STALL_LIMIT = 300000;
  localparam int RAND_CMDS   = 1030;

  typedef struct {
    req_t r;
    bit   drain;
  } pend_t;

  logic clk;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  fat_cluster_chain_allocator u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  logic [27:0] fat_links [USABLE];
  logic [16:0] free_cnt;
  logic [16:0] link_hint;
  int          chain_heads[$];
  pend_t       pending[$];
  rsp_t        exp_rsp_q[$];
  int          acc_cnt  = 0;
  int          done_cnt = 0;
  int          err_cnt  = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit in_range(int c);
    return c >= 2 && c < USABLE;
  endfunction

  function automatic rsp_t model_cmd(req_t r);
    rsp_t        o;
    int          c, cur, nxt, first_cl, prev_cl, left, steps;
    bit          have, walking;
    logic [27:0] old;
    o = '0;
    o.status = ST_OK;
    case (r.cmd)
      CMD_ALLOC: begin
        if (r.count == 0 || r.count > free_cnt) begin
          o.status = ST_NO_SPACE;
        end else begin
          have = 1'b0;
          first_cl = 0;
          prev_cl = 0;
          left = r.count;
          for (c = link_hint; c < USABLE && left > 0; c++) begin
            if (fat_links[c] == 0) begin
              if (have) fat_links[prev_cl] = c;
              else first_cl = c;
              have = 1'b1;
              prev_cl = c;
              left--;
            end
          end
          if (!have) begin
            o.status = ST_NO_SPACE;
          end else begin
            fat_links[prev_cl] = LINK_EOC;
            free_cnt = free_cnt - (r.count - left);
            for (c = prev_cl + 1; c < USABLE; c++)
              if (fat_links[c] == 0) break;
            link_hint = c;
            o.result_value = first_cl;
            chain_heads.push_back(first_cl);
          end
        end
      end
      CMD_FREE: begin
        cur = r.cluster;
        if (!in_range(cur) || fat_links[cur] == 0) begin
          o.status = ST_BAD_LINK;
        end else begin
          walking = 1'b1;
          steps = 0;
          while (walking && steps < USABLE) begin
            nxt = fat_links[cur];
            fat_links[cur] = '0;
            free_cnt++;
            if (cur < link_hint) link_hint = cur;
            if (nxt >= LINK_EOC_MIN) begin
              walking = 1'b0;
            end else if (!in_range(nxt) || fat_links[nxt] == 0) begin
              o.status = ST_BAD_LINK;
              walking = 1'b0;
            end else begin
              cur = nxt;
            end
            steps++;
          end
          if (walking) o.status = ST_BAD_LINK;
        end
      end
      CMD_READ: begin
        if (!in_range(r.cluster)) o.status = ST_BAD_LINK;
        else o.result_value = fat_links[r.cluster];
      end
      default: begin
        if (!in_range(r.cluster)) begin
          o.status = ST_BAD_LINK;
        end else begin
          old = fat_links[r.cluster];
          if (old == 0 && r.value != 0) begin
            free_cnt--;
          end else if (old != 0 && r.value == 0) begin
            free_cnt++;
            if (r.cluster < link_hint) link_hint = r.cluster;
          end
          fat_links[r.cluster] = r.value;
        end
      end
    endcase
    o.free_left = free_cnt;
    return o;
  endfunction

  task automatic queue_cmd(cmd_t c, int cl, int cnt, int v, bit drain = 1'b0);
    pend_t p;
    p.r.cmd     = c;
    p.r.cluster = cl;
    p.r.count   = cnt;
    p.r.value   = v;
    p.drain     = drain;
    pending.push_back(p);
  endtask

  // driver: bursts with random gaps, prediction at each accepted request
  always @(posedge clk) begin
    pend_t p;
    logic  nxt_start;
    req_t  nxt_req;
    if (rst) begin
      start <= 1'b0;
      req <= '0;
      foreach (fat_links[i]) fat_links[i] = '0;
      free_cnt = USABLE - 2;
      link_hint = 2;
      burst_left = 0;
      gap_left = 0;
    end else begin
      nxt_start = start;
      nxt_req = req;
      if (start && !busy) begin
        exp_rsp_q.push_back(model_cmd(req));
        acc_cnt++;
        nxt_start = 1'b0;
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0 && !(pending[0].drain && acc_cnt != done_cnt)) begin
          p = pending.pop_front();
          nxt_start = 1'b1;
          nxt_req = p.r;
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      start <= nxt_start;
      req <= nxt_req;
    end
  end

  // monitor: every done strobe is checked against the oldest prediction
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      done_cnt <= done_cnt + 1;
      if (exp_rsp_q.size() == 0) begin
        if (err_cnt < 10)
          $display("unexpected response: status %0d value %h free %0d",
                   rsp.status, rsp.result_value, rsp.free_left);
        err_cnt++;
      end else begin
        want = exp_rsp_q.pop_front();
        if (rsp.status !== want.status || rsp.result_value !== want.result_value ||
            rsp.free_left !== want.free_left) begin
          if (err_cnt < 10)
            $display("mismatch at response %0d: status %0d/%0d value %h/%h free %0d/%0d",
                     done_cnt, want.status, rsp.status, want.result_value,
                     rsp.result_value, want.free_left, rsp.free_left);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int   n, k, idx, cl, cnt, v;
    cmd_t c;
    // fill the whole table, then release it as one chain
    queue_cmd(CMD_ALLOC, 0, 0, 0);
    queue_cmd(CMD_ALLOC, 0, 65536, 0);
    queue_cmd(CMD_ALLOC, 65535, 65534, 28'hFFFFFFF);
    queue_cmd(CMD_ALLOC, 0, 1, 0);
    queue_cmd(CMD_READ, 65535, 0, 0);
    queue_cmd(CMD_FREE, 2, 0, 0, 1'b1);
    queue_cmd(CMD_READ, 0, 0, 0);
    queue_cmd(CMD_READ, 1, 0, 0);
    queue_cmd(CMD_ALLOC, 0, 3, 0);
    queue_cmd(CMD_READ, 2, 0, 0);
    queue_cmd(CMD_FREE, 0, 0, 0);
    queue_cmd(CMD_FREE, 65535, 0, 0);
    queue_cmd(CMD_WRITE, 65535, 0, 28'hFFFFFFF);
    queue_cmd(CMD_FREE, 65535, 0, 0);
    // link of one inside a chain
    queue_cmd(CMD_WRITE, 3, 0, 1);
    queue_cmd(CMD_FREE, 2, 0, 0);
    queue_cmd(CMD_FREE, 4, 0, 0);
    // two-entry loop
    queue_cmd(CMD_WRITE, 10, 0, 11);
    queue_cmd(CMD_WRITE, 11, 0, 10);
    queue_cmd(CMD_FREE, 10, 0, 0);
    queue_cmd(CMD_WRITE, 20, 0, 28'hFFFFFF8);
    queue_cmd(CMD_FREE, 20, 0, 0);
    queue_cmd(CMD_WRITE, 21, 0, 28'hFFFFFF7);
    queue_cmd(CMD_FREE, 21, 0, 0);
    queue_cmd(CMD_WRITE, 22, 0, USABLE);
    queue_cmd(CMD_FREE, 22, 131071, 28'h0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < RAND_CMDS; n++) begin
      while (pending.size() >= 2) @(negedge clk);
      k = $urandom_range(0, 99);
      cl = $urandom_range(0, 65535);
      cnt = $urandom_range(0, 131071);
      v = $urandom() & 28'hFFFFFFF;
      if (k < 35) begin
        c = CMD_ALLOC;
        k = $urandom_range(0, 99);
        if (k < 3) cnt = 0;
        else if (k < 6) cnt = $urandom_range(65536, 131071);
        else if (k < 8) cnt = free_cnt + 1;
        else if (k < 20) cnt = $urandom_range(1, 64);
        else cnt = $urandom_range(1, 8);
      end else if (k < 65) begin
        c = CMD_FREE;
        if (chain_heads.size() > 0 && $urandom_range(0, 4) != 0) begin
          idx = $urandom_range(0, chain_heads.size() - 1);
          cl = chain_heads[idx];
          chain_heads.delete(idx);
        end else if ($urandom_range(0, 1) == 0) begin
          cl = $urandom_range(0, 300);
        end
      end else if (k < 83) begin
        c = CMD_READ;
        if ($urandom_range(0, 1) == 0) cl = $urandom_range(0, 300);
      end else begin
        c = CMD_WRITE;
        if ($urandom_range(0, 4) < 3) cl = $urandom_range(0, 300);
        k = $urandom_range(0, 99);
        if (k < 25) v = 0;
        else if (k < 50) v = $urandom_range(2, 300);
        else if (k < 65) v = $urandom_range(28'hFFFFFF8, 28'hFFFFFFF);
        else if (k < 75) v = $urandom_range(USABLE, 28'hFFFFFF7);
        else if (k < 80) v = 1;
        if (v != 0 && in_range(cl)) chain_heads.push_back(cl);
      end
      queue_cmd(c, cl, cnt, v, $urandom_range(0, 99) < 3);
    end

    while (pending.size() > 0 || start || done_cnt < acc_cnt) @(negedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0 && exp_rsp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
